/* rtl/core/dq_pkg.sv */
`timescale 1ns / 1ps

package dq_pkg;

    localparam int KIND_BITS    = 3;
    localparam int STATUS_BITS  = 2;
    localparam int PAYLOAD_BITS = 32;
    localparam int COUNT_BITS   = 5;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_PUSH_REAR  = 3'd0,
        KIND_POP_REAR   = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_PEEK_REAR  = 3'd3,
        KIND_PEEK_FRONT = 3'd4
    } t_kind;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;
        logic shift;
    } t_cell_ctl;

endpackage

/* rtl/core/dq_if.sv */
`timescale 1ns / 1ps

interface dq_req_if;
    logic                                    valid;
    logic                                    ready;
    dq_pkg::t_kind                           kind;
    logic [dq_pkg::PAYLOAD_BITS-1:0]         push_word;

    modport source (output valid, output kind, output push_word, input ready);
    modport sink   (input valid, input kind, input push_word, output ready);
endinterface

interface dq_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic [dq_pkg::PAYLOAD_BITS-1:0]         read_word;
    dq_pkg::t_status                         status;
    logic [dq_pkg::COUNT_BITS-1:0]           entry_count;

    modport source (output valid, output read_word, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_word, input status, input entry_count,
                    output ready);
endinterface

/* rtl/core/dq_cell.sv */
`timescale 1ns / 1ps

module dq_cell #(
    parameter int WORD_BITS = 32,
    parameter int CNT_BITS  = 5,
    parameter int INDEX     = 0
) (
    input  logic                 i_clk,
    input  dq_pkg::t_cell_ctl    i_ctl,
    input  logic [CNT_BITS-1:0]  i_count,
    input  logic [WORD_BITS-1:0] i_push_word,
    input  logic [WORD_BITS-1:0] i_next_word,
    output logic [WORD_BITS-1:0] o_word,
    output logic [WORD_BITS-1:0] o_rear_tap
);
    import dq_pkg::*;

    logic [WORD_BITS-1:0] r_word;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_word <= i_next_word;
        end else if (i_ctl.push && (i_count == CNT_BITS'(INDEX))) begin
            r_word <= i_push_word;
        end
    end

    assign o_word     = r_word;
    // this cell is the rear when it is the last occupied one
    assign o_rear_tap = (i_count == CNT_BITS'(INDEX + 1)) ? r_word : '0;

endmodule

/* rtl/core/double_ended_queue.sv */
`timescale 1ns / 1ps
// The result is registered and is valid in the cycle after the request is accepted.
// Throughput: one item per cycle while the response side takes results; the result register frees as it is taken.
// Storage is a row of DEPTH cells with the front in cell 0; a front pop shifts the row.
// Reset (synchronous, active low) empties the queue and drops any pending result.
// Cell contents are not cleared by reset and are never read before written.
module double_ended_queue #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dq_req_if.sink        i_req,
    dq_rsp_if.source      o_rsp
);
    import dq_pkg::*;

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [CNT_BITS-1:0]     r_count;
    logic [CNT_BITS-1:0]     n_count;
    logic                    r_out_valid;
    logic [PAYLOAD_BITS-1:0] r_read_word;
    t_status                 r_status;
    logic [COUNT_BITS-1:0]   r_entry_count;

    logic                    accept;
    logic                    empty;
    logic                    full;
    t_cell_ctl               cell_ctl;
    t_status                 status;
    logic [WORD_BITS-1:0]    rd_word;
    logic [WORD_BITS-1:0]    rear_word;
    logic [WORD_BITS-1:0]    push_word;
    logic [PAYLOAD_BITS-1:0] rd_payload;
    logic [COUNT_BITS-1:0]   count_out;

    logic [WORD_BITS-1:0]    w_word [DEPTH+1];
    logic [WORD_BITS-1:0]    w_tap  [DEPTH];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign empty       = (r_count == '0);
    assign full        = (r_count == CNT_BITS'(DEPTH));

    generate
        if (WORD_BITS >= PAYLOAD_BITS) begin : g_wide
            assign push_word  = WORD_BITS'(i_req.push_word);
            assign rd_payload = rd_word[PAYLOAD_BITS-1:0];
        end else begin : g_narrow
            assign push_word  = i_req.push_word[WORD_BITS-1:0];
            assign rd_payload = PAYLOAD_BITS'(rd_word);
        end
        if (CNT_BITS >= COUNT_BITS) begin : g_cnt_wide
            assign count_out = n_count[COUNT_BITS-1:0];
        end else begin : g_cnt_narrow
            assign count_out = COUNT_BITS'(n_count);
        end
    endgenerate

    assign w_word[DEPTH] = '0;

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            dq_cell #(
                .WORD_BITS (WORD_BITS),
                .CNT_BITS  (CNT_BITS),
                .INDEX     (i)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl),
                .i_count     (r_count),
                .i_push_word (push_word),
                .i_next_word (w_word[i+1]),
                .o_word      (w_word[i]),
                .o_rear_tap  (w_tap[i])
            );
        end
    endgenerate

    always_comb begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rear_word = rear_word | w_tap[i];
        end
    end

    always_comb begin
        cell_ctl = '0;
        status   = ST_OK;
        rd_word  = '0;
        n_count  = r_count;
        case (i_req.kind)
            KIND_PUSH_REAR: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cell_ctl.push = accept;
                    n_count       = r_count + 1'b1;
                end
            end
            KIND_POP_REAR, KIND_PEEK_REAR: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    rd_word = rear_word;
                    if (i_req.kind == KIND_POP_REAR) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            KIND_POP_FRONT, KIND_PEEK_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    rd_word = w_word[0];
                    if (i_req.kind == KIND_POP_FRONT) begin
                        cell_ctl.shift = accept;
                        n_count        = r_count - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_word   <= rd_payload;
            r_status      <= status;
            r_entry_count <= count_out;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_word   = r_read_word;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = r_entry_count;

endmodule
